// File: rtl/bitmap_next_fit_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_NEXT_FIT_ALLOCATOR_DEFINES_SVH
`define BITMAP_NEXT_FIT_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BNFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BNFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bnfa_pkg.sv
// Types, constants and helper functions of the bitmap next-fit allocator.
package bnfa_pkg;

    localparam int DEF_NUM_GRANULES  = 1024;
    localparam int DEF_GRANULE_BYTES = 64;

    // Field widths of the transactions and the pool size register.
    localparam int CMD_W  = 2;
    localparam int REQ_W  = 16;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 2;
    localparam int OFF_W  = 17;
    localparam int POOL_W = 11;

    localparam int REQ_MAX      = (1 << REQ_W) - 1;
    localparam int HEADER_BYTES = 4;
    localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

    // The bitmap is stored as words of this many used bits.
    localparam int WORD_W = 32;
    localparam int WB     = $clog2(WORD_W);
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [WB-1:0]     t_bit_off;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LEN,
        S_SCAN,
        S_ASET,
        S_FREE_RD,
        S_FREE_LEN,
        S_RMW,
        S_RESULT
    } t_state;

    // Bits at and above off.
    function automatic t_word mask_ge(input t_bit_off off);
        t_word m;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = (b >= int'(off));
        end
        return m;
    endfunction

    // Bits at and below off.
    function automatic t_word mask_le(input t_bit_off off);
        t_word m;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = (b <= int'(off));
        end
        return m;
    endfunction

endpackage

// File: rtl/bitmap_next_fit_allocator.sv
// Bitmap next-fit granule allocator: word-wide bitmap memory, length table and control.
//
// The block keeps one used bit per granule in a word-organized bitmap memory (32 granules a
// word) and the length of each allocated run in a table memory. One transaction is processed
// at a time; the input stalls while it is busy, and a finished result waits in the output
// register while the next transaction is taken. Allocate searches the bitmap word by word,
// at most two passes over the pool, and on success sets the used bits of each word that
// the new run touches. Free reads the run length from the table and clears the bits of each
// word of the freed run; clear sweeps every bitmap word clear. The bitmap read port paces
// the word scans at one word per cycle.
// After reset the bitmap is swept clear, one word a cycle, and no transaction is taken until
// the sweep is done; pool size writes are taken at any time.
`include "bitmap_next_fit_allocator_defines.svh"

module bitmap_next_fit_allocator #(
    parameter int NUM_GRANULES  = bnfa_pkg::DEF_NUM_GRANULES,
    parameter int GRANULE_BYTES = bnfa_pkg::DEF_GRANULE_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bnfa_pkg::POOL_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bnfa_pkg::CMD_W-1:0]  i_cmd,
    input  logic [bnfa_pkg::REQ_W-1:0]  i_req_bytes,
    input  logic [bnfa_pkg::IDX_W-1:0]  i_granule_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bnfa_pkg::STAT_W-1:0] o_status,
    output logic [bnfa_pkg::IDX_W-1:0]  o_start_granule,
    output logic [bnfa_pkg::OFF_W-1:0]  o_data_offset
);
    import bnfa_pkg::*;

    localparam int GW        = $clog2(NUM_GRANULES);
    localparam int PW        = $clog2(NUM_GRANULES + 1);
    localparam int NWORDS    = (NUM_GRANULES + WORD_W - 1) / WORD_W;
    localparam int WA_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int MAX_LEN   = (REQ_MAX + HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int X_W       = $clog2(REQ_MAX + HEADER_BYTES + GRANULE_BYTES);
    localparam int SH        = X_W + $clog2(GRANULE_BYTES);
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SH) + 64'(GRANULE_BYTES) - 64'd1) / 64'(GRANULE_BYTES);
    localparam int M_W       = $clog2(RECIP64 + 64'd1);
    localparam logic [M_W-1:0] RECIP = M_W'(RECIP64);
    localparam int G_W       = $clog2(GRANULE_BYTES + 1);
    localparam int O_W       = PW + G_W;
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NWORDS - 1);

    // Memories.
    t_word            r_bitmap_mem [NWORDS];
    logic [LEN_W-1:0] r_len_mem    [NUM_GRANULES];
    t_word            r_bm_rdata;
    logic [LEN_W-1:0] r_tbl_q;

    // Control registers.
    t_state           r_state, n_state;
    logic [WA_W-1:0]  r_clr, n_clr;
    logic             r_clr_emit, n_clr_emit;
    logic [POOL_W-1:0] r_pool;
    logic [PW-1:0]    r_pos, n_pos;
    logic             r_dv, n_dv;
    logic             r_iss_ok, n_iss_ok;
    logic             r_out_valid;

    // Payload registers.
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_run, n_run;
    logic [PW-1:0]     r_rs, n_rs;
    logic [PW-1:0]     r_rl, n_rl;
    logic [WA_W-1:0]   r_iss, n_iss;
    logic [WA_W-1:0]   r_dv_addr, n_dv_addr;
    logic              r_pass_b, n_pass_b;
    logic              r_set, n_set;
    logic [WA_W-1:0]   r_hit_wd, n_hit_wd;
    logic [WB-1:0]     r_hit_p, n_hit_p;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [PW-1:0]     r_res_start, n_res_start;
    logic              r_res_alloc, n_res_alloc;
    logic [STAT_W-1:0] r_out_status;
    logic [IDX_W-1:0]  r_out_start;
    logic [OFF_W-1:0]  r_out_offset;

    // Memory controls.
    logic              w_bm_we, w_bm_re, w_tbl_we, w_tbl_re;
    logic [WA_W-1:0]   w_bm_waddr, w_bm_raddr;
    t_word             w_bm_wdata;

    // Combinational helpers.
    logic [PW-1:0]     w_pool;
    logic              w_scan_a, w_scan_b, w_idx_bad, w_out_free;
    logic [WA_W-1:0]   w_first_wd, w_last_wd;
    t_word             w_inrange, w_used;
    logic              w_found;
    logic [WB-1:0]     w_hit_p;
    logic [LEN_W-1:0]  w_run_next;
    logic [X_W-1:0]    w_x;
    logic [X_W+M_W-1:0] w_prod;
    logic [PW-1:0]     w_hit_start, w_hit_end, w_avail;
    logic [O_W-1:0]    w_off_full;
    logic              w_eng_go;
    logic [PW-1:0]     w_eng_rs, w_eng_rl;

    assign w_pool = (32'(r_pool) > 32'(NUM_GRANULES)) ? PW'(NUM_GRANULES) : PW'(r_pool);
    assign w_scan_a   = (r_pos < w_pool);
    assign w_scan_b   = (r_pos != '0) && (w_pool != '0);
    assign w_idx_bad  = (32'(r_idx) >= 32'(w_pool));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_avail    = w_pool - PW'(r_idx);

    assign w_first_wd = WA_W'(r_rs >> WB);
    assign w_last_wd  = WA_W'(r_rl >> WB);
    assign w_inrange  = ((r_dv_addr == w_first_wd) ? mask_ge(t_bit_off'(r_rs)) : '1) &
                        ((r_dv_addr == w_last_wd)  ? mask_le(t_bit_off'(r_rl)) : '1);
    // Granules outside the search range count as used, so no run crosses its edges.
    assign w_used     = r_bm_rdata | ~w_inrange;

    // Granule count is a multiply by the reciprocal of the granule size; exact over the
    // whole request range.
    assign w_x    = X_W'(r_req) + X_W'(HEADER_BYTES + GRANULE_BYTES - 1);
    assign w_prod = (X_W+M_W)'(w_x) * (X_W+M_W)'(RECIP);

    assign w_hit_start = (PW'(r_hit_wd) << WB) + PW'(r_hit_p) + PW'(1) - PW'(r_len);
    assign w_hit_end   = w_hit_start + PW'(r_len);

    assign w_off_full  = O_W'(r_res_start) * O_W'(GRANULE_BYTES) + O_W'(HEADER_BYTES);

    // Word evaluation: a run of r_len free granules ends at bit p when the bits from
    // p-len+1 up to p are free, with the free run carried in from lower words covering
    // the part of the window that lies below this word.
    always_comb begin : word_eval
        t_word       ok;
        t_word       win;
        logic [31:0] lo_start;
        int          top;
        ok       = '0;
        win      = '0;
        lo_start = '0;
        top      = 0;
        for (int p = 0; p < WORD_W; p++) begin
            if (32'(r_len) <= 32'(p) + 32'd1) begin
                lo_start = 32'(p) + 32'd1 - 32'(r_len);
            end else begin
                lo_start = 32'd0;
            end
            win   = mask_le(t_bit_off'(p)) & mask_ge(t_bit_off'(lo_start));
            ok[p] = ((w_used & win) == '0) &&
                    (32'(r_run) + 32'(p) + 32'd1 >= 32'(r_len));
        end
        w_found = (ok != '0);
        w_hit_p = '0;
        for (int p = WORD_W - 1; p >= 0; p--) begin
            if (ok[p]) begin
                w_hit_p = WB'(p);
            end
        end
        for (int b = 0; b < WORD_W; b++) begin
            if (w_used[b]) begin
                top = b;
            end
        end
        if (w_used == '0) begin
            w_run_next = LEN_W'(32'(r_run) + 32'(WORD_W));
        end else begin
            w_run_next = LEN_W'(WORD_W - 1 - top);
        end
    end

    // Next state.
    always_comb begin : state_next
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == LAST_WORD) begin
                    n_state = r_clr_emit ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_ALLOC: n_state = S_LEN;
                        CMD_FREE:  n_state = S_FREE_RD;
                        CMD_CLEAR: n_state = S_CLR;
                        default:   n_state = S_RESULT;
                    endcase
                end
            end
            S_LEN: begin
                n_state = (w_scan_a || w_scan_b) ? S_SCAN : S_RESULT;
            end
            S_SCAN: begin
                if (r_dv) begin
                    if (w_found) begin
                        n_state = S_ASET;
                    end else if (r_dv_addr == w_last_wd) begin
                        n_state = (!r_pass_b && r_pos != '0) ? S_SCAN : S_RESULT;
                    end
                end
            end
            S_ASET:     n_state = S_RMW;
            S_FREE_RD:  n_state = w_idx_bad ? S_RESULT : S_FREE_LEN;
            S_FREE_LEN: n_state = (r_tbl_q == '0) ? S_RESULT : S_RMW;
            S_RMW: begin
                if (r_dv && r_dv_addr == w_last_wd) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin : datapath_next
        n_clr        = r_clr;
        n_clr_emit   = r_clr_emit;
        n_pos        = r_pos;
        n_dv         = 1'b0;
        n_iss_ok     = r_iss_ok;
        n_cmd        = r_cmd;
        n_req        = r_req;
        n_idx        = r_idx;
        n_len        = r_len;
        n_run        = r_run;
        n_rs         = r_rs;
        n_rl         = r_rl;
        n_iss        = r_iss;
        n_dv_addr    = r_dv_addr;
        n_pass_b     = r_pass_b;
        n_set        = r_set;
        n_hit_wd     = r_hit_wd;
        n_hit_p      = r_hit_p;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_alloc  = r_res_alloc;
        w_bm_we      = 1'b0;
        w_bm_waddr   = r_dv_addr;
        w_bm_wdata   = r_bm_rdata;
        w_bm_re      = 1'b0;
        w_bm_raddr   = r_iss;
        w_tbl_we     = 1'b0;
        w_tbl_re     = 1'b0;
        w_eng_go     = 1'b0;
        w_eng_rs     = '0;
        w_eng_rl     = w_pool - PW'(1);

        // Shared word pipeline: one read issued per cycle, data evaluated in the next cycle.
        if (r_state == S_SCAN || r_state == S_RMW) begin
            w_bm_re   = r_iss_ok;
            n_dv      = r_iss_ok;
            n_dv_addr = r_iss;
            if (r_iss == w_last_wd) begin
                n_iss_ok = 1'b0;
            end else begin
                n_iss = r_iss + WA_W'(1);
            end
        end

        case (r_state)
            S_CLR: begin
                w_bm_we    = 1'b1;
                w_bm_waddr = r_clr;
                w_bm_wdata = '0;
                n_clr      = (r_clr == LAST_WORD) ? '0 : r_clr + WA_W'(1);
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_cmd;
                    n_req        = i_req_bytes;
                    n_idx        = i_granule_index;
                    n_res_status = STAT_OK;
                    n_res_start  = '0;
                    n_res_alloc  = 1'b0;
                    if (i_cmd == CMD_CLEAR) begin
                        n_clr      = '0;
                        n_clr_emit = 1'b1;
                    end
                end
            end
            S_LEN: begin
                n_len = LEN_W'(w_prod >> SH);
                if (w_scan_a) begin
                    w_eng_go = 1'b1;
                    w_eng_rs = r_pos;
                    n_pass_b = 1'b0;
                end else if (w_scan_b) begin
                    w_eng_go = 1'b1;
                    n_pass_b = 1'b1;
                end else begin
                    n_res_status = STAT_NOSPACE;
                end
            end
            S_SCAN: begin
                if (r_dv) begin
                    if (w_found) begin
                        n_hit_wd = r_dv_addr;
                        n_hit_p  = w_hit_p;
                        n_dv     = 1'b0;
                    end else if (r_dv_addr == w_last_wd) begin
                        // The second pass starts over from granule zero with an empty run.
                        if (!r_pass_b && r_pos != '0) begin
                            w_eng_go = 1'b1;
                            n_pass_b = 1'b1;
                        end else begin
                            n_res_status = STAT_NOSPACE;
                        end
                    end else begin
                        n_run = w_run_next;
                    end
                end
            end
            S_ASET: begin
                w_tbl_we    = 1'b1;
                n_pos       = (w_hit_end >= w_pool) ? '0 : w_hit_end;
                n_res_start = w_hit_start;
                n_res_alloc = 1'b1;
                n_set       = 1'b1;
                w_eng_go    = 1'b1;
                w_eng_rs    = w_hit_start;
                w_eng_rl    = w_hit_end - PW'(1);
            end
            S_FREE_RD: begin
                w_tbl_re = !w_idx_bad;
                if (w_idx_bad) begin
                    n_res_status = STAT_RANGE;
                end
            end
            S_FREE_LEN: begin
                n_set    = 1'b0;
                w_eng_go = (r_tbl_q != '0);
                w_eng_rs = PW'(r_idx);
                // A run reaching past the pool end is cleared only up to the end.
                if (32'(r_tbl_q) > 32'(w_avail)) begin
                    w_eng_rl = w_pool - PW'(1);
                end else begin
                    w_eng_rl = PW'(r_idx) + PW'(r_tbl_q) - PW'(1);
                end
            end
            S_RMW: begin
                if (r_dv) begin
                    w_bm_we    = 1'b1;
                    w_bm_waddr = r_dv_addr;
                    w_bm_wdata = r_set ? (r_bm_rdata | w_inrange) : (r_bm_rdata & ~w_inrange);
                end
            end
            default: begin
            end
        endcase

        if (w_eng_go) begin
            n_rs     = w_eng_rs;
            n_rl     = w_eng_rl;
            n_iss    = WA_W'(w_eng_rs >> WB);
            n_iss_ok = 1'b1;
            n_dv     = 1'b0;
            n_run    = '0;
        end
    end

    // Bitmap memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_bm_we) begin
            r_bitmap_mem[w_bm_waddr] <= w_bm_wdata;
        end
        if (w_bm_re) begin
            r_bm_rdata <= r_bitmap_mem[w_bm_raddr];
        end
    end

    // Run length table.
    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_len_mem[GW'(w_hit_start)] <= r_len;
        end
        if (w_tbl_re) begin
            r_tbl_q <= r_len_mem[GW'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_clr_emit  <= 1'b0;
            r_pool      <= POOL_RESET;
            r_pos       <= '0;
            r_dv        <= 1'b0;
            r_iss_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_clr_emit <= (r_state == S_CLR && r_clr == LAST_WORD) ? 1'b0 : n_clr_emit;
            r_pos      <= n_pos;
            r_dv       <= n_dv;
            r_iss_ok   <= n_iss_ok;
            if (i_cfg_we) begin
                r_pool <= i_cfg_data;
            end
            if (r_state == S_RESULT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_len        <= n_len;
        r_run        <= n_run;
        r_rs         <= n_rs;
        r_rl         <= n_rl;
        r_iss        <= n_iss;
        r_dv_addr    <= n_dv_addr;
        r_pass_b     <= n_pass_b;
        r_set        <= n_set;
        r_hit_wd     <= n_hit_wd;
        r_hit_p      <= n_hit_p;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_alloc  <= n_res_alloc;
        if (r_state == S_RESULT && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_start  <= IDX_W'(r_res_start);
            r_out_offset <= r_res_alloc ? OFF_W'(w_off_full) : '0;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_start_granule = r_out_start;
    assign o_data_offset   = r_out_offset;

    // The unused command code is latched but needs no further decoding.
    logic w_cmd_is_alloc;
    assign w_cmd_is_alloc = (r_cmd == CMD_ALLOC);

    `BNFA_ASSERT_NOW(a_dv_in_range, i_clk, i_rst_n, r_dv,
        r_dv_addr >= w_first_wd && r_dv_addr <= w_last_wd,
        "evaluated bitmap word lies outside the active range")
    `BNFA_ASSERT_NOW(a_hit_in_range, i_clk, i_rst_n, r_state == S_ASET,
        w_cmd_is_alloc && w_hit_start >= r_rs && w_hit_end - PW'(1) <= r_rl,
        "found run lies outside the searched range")
    `BNFA_ASSERT_NEXT(a_pos_wraps, i_clk, i_rst_n, r_state == S_ASET,
        r_pos == '0 || r_pos < w_pool,
        "search position was left at or past the pool end")
    `BNFA_ASSERT_NOW(a_out_from_result, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == S_RESULT,
        "result presented without passing through the result state")

endmodule
